// File: rtl/tbra_pkg.sv
package tbra_pkg;
   localparam int unsigned ENTRIES_DEFAULT = 1024;
   localparam int unsigned INDEX_W = 10;
   localparam int unsigned COUNT_W = 11;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_PROBE = 2'd2;
   localparam logic [1:0] OP_BAD   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_ZERO    = 2'd2;
   localparam logic [1:0] ST_BAD     = 2'd3;

   localparam logic [1:0] MARK_FREE  = 2'd0;
   localparam logic [1:0] MARK_USED  = 2'd1;
   localparam logic [1:0] MARK_BOUND = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [INDEX_W-1:0] index;
      logic [COUNT_W-1:0] count;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [INDEX_W-1:0] first_index;
      logic [INDEX_W-1:0] last_index;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0]         kind;
      logic               done;
      logic [1:0]         status;
      logic [INDEX_W-1:0] index;
      logic [COUNT_W-1:0] count;
   } cmd_type;
endpackage

// File: rtl/tbra_if.sv
interface tbra_req_if;
   import tbra_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tbra_rsp_if;
   import tbra_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/tbra_front.sv
module tbra_front #(
   parameter int unsigned ENTRIES = tbra_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   tbra_req_if.sink          req,
   output logic              q_valid,
   input  logic              q_ready,
   output tbra_pkg::cmd_type q_cmd
);
   import tbra_pkg::*;
   localparam int DEPTH = 2;

   cmd_type    slot_ff [DEPTH];
   cmd_type    cls;
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   always_comb begin
      cls.kind = req.payload.operation;
      cls.index = req.payload.index;
      cls.count = req.payload.count;
      cls.done = 1'b0;
      cls.status = ST_OK;
      if (req.payload.operation == OP_FREE) begin
         if ({22'd0, req.payload.index} >= ENTRIES) begin
            cls.done = 1'b1;
            cls.status = ST_BAD;
            cls.index = '0;
         end
      end else if (req.payload.operation inside {OP_ALLOC, OP_PROBE}) begin
         if (req.payload.count == '0) begin
            cls.done = 1'b1;
            cls.status = ST_ZERO;
            cls.index = '0;
         end else if ({21'd0, req.payload.count} > ENTRIES) begin
            cls.done = 1'b1;
            cls.status = ST_NOSPACE;
            cls.index = '0;
         end
      end else begin
         cls.done = 1'b1;
         cls.status = ST_BAD;
         cls.index = '0;
      end
   end

   assign req.ready = (cnt_ff != 2'(DEPTH));
   assign push = req.valid && req.ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_cmd = slot_ff[rp_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
      if (push) slot_ff[wp_ff] <= cls;
   end
endmodule

// File: rtl/tbra_back.sv
module tbra_back #(
   parameter int unsigned ENTRIES = tbra_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  tbra_pkg::cmd_type q_cmd,
   tbra_rsp_if.source        rsp
);
   import tbra_pkg::*;
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_SCAN   = 4'd2;
   localparam logic [3:0] S_SCANW  = 4'd3;
   localparam logic [3:0] S_MARK   = 4'd4;
   localparam logic [3:0] S_FREAD  = 4'd5;
   localparam logic [3:0] S_FWAIT  = 4'd6;
   localparam logic [3:0] S_WALK   = 4'd7;
   localparam logic [3:0] S_WALKW  = 4'd8;
   localparam logic [3:0] S_CLR    = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   logic [1:0]    mem [ENTRIES];
   logic [1:0]    rd_ff;
   logic [3:0]    state_ff;
   logic [AW:0]   ptr_ff;     // scan/read address, one bit wider than an entry address
   logic [AW-1:0] last_rd_ff; // address whose data sits in rd_ff
   logic [AW:0]   streak_ff;
   logic [AW-1:0] lo_ff, hi_ff, wa_ff;
   cmd_type       cmd_ff;
   rsp_type       out_ff;
   logic          ov_ff;
   logic          we;
   logic [1:0]    wd;
   logic [AW:0]   streak_nx;

   assign q_ready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp.valid = ov_ff;
   assign rsp.payload = out_ff;
   assign streak_nx = (rd_ff == MARK_FREE) ? streak_ff + 1'b1 : '0;

   always_comb begin
      we = 1'b0;
      wd = MARK_FREE;
      case (state_ff)
         S_CLEAR: we = 1'b1;
         S_MARK: begin
            we = 1'b1;
            if (cmd_ff.count == 11'd1) wd = MARK_USED;
            else if (wa_ff == lo_ff || wa_ff == hi_ff) wd = MARK_BOUND;
            else wd = MARK_USED;
         end
         S_CLR: we = 1'b1;
         default: we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa_ff] <= wd;
      rd_ff <= mem[ptr_ff[AW-1:0]];
      last_rd_ff <= ptr_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         wa_ff <= '0;
         ov_ff <= 1'b0;
         ptr_ff <= '0;
      end else begin
         if (rsp.valid && rsp.ready) ov_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               // one entry per cycle after reset
               wa_ff <= wa_ff + 1'b1;
               if ({{(32-AW){1'b0}}, wa_ff} == ENTRIES - 1) state_ff <= S_IDLE;
            end
            S_IDLE: if (q_valid && !ov_ff) begin
               cmd_ff <= q_cmd;
               if (q_cmd.done) begin
                  out_ff <= '{q_cmd.status, q_cmd.index, '0};
                  ov_ff <= 1'b1;
               end else if (q_cmd.kind == OP_FREE) begin
                  ptr_ff <= {1'b0, q_cmd.index[AW-1:0]};
                  state_ff <= S_FREAD;
               end else begin
                  ptr_ff <= '0;
                  streak_ff <= '0;
                  state_ff <= S_SCANW;
               end
            end
            S_SCANW: begin
               ptr_ff <= ptr_ff + 1'b1;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               // rd_ff holds mark of last_rd_ff
               streak_ff <= streak_nx;
               if ({{(31-AW){1'b0}}, streak_nx} == {21'd0, cmd_ff.count}) begin
                  hi_ff <= last_rd_ff;
                  lo_ff <= AW'(last_rd_ff - AW'(cmd_ff.count) + 1'b1);
                  wa_ff <= AW'(last_rd_ff - AW'(cmd_ff.count) + 1'b1);
                  if (cmd_ff.kind == OP_ALLOC) state_ff <= S_MARK;
                  else begin
                     out_ff <= '{ST_OK,
                        INDEX_W'(last_rd_ff - AW'(cmd_ff.count) + 1'b1),
                        INDEX_W'(last_rd_ff)};
                     ov_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end else if ({{(32-AW){1'b0}}, last_rd_ff} == ENTRIES - 1) begin
                  out_ff <= '{ST_NOSPACE, '0, '0};
                  ov_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else ptr_ff <= ptr_ff + 1'b1;
            end
            S_MARK: begin
               wa_ff <= wa_ff + 1'b1;
               if (wa_ff == hi_ff) begin
                  out_ff <= '{ST_OK, INDEX_W'(lo_ff), INDEX_W'(hi_ff)};
                  ov_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_FREAD: state_ff <= S_FWAIT;
            S_FWAIT: begin
               lo_ff <= last_rd_ff;
               wa_ff <= last_rd_ff;
               if (rd_ff == MARK_USED) begin
                  hi_ff <= last_rd_ff;
                  state_ff <= S_CLR;
               end else if (rd_ff != MARK_BOUND) begin
                  out_ff <= '{ST_OK, cmd_ff.index, cmd_ff.index};
                  ov_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if ({{(32-AW){1'b0}}, last_rd_ff} == ENTRIES - 1) begin
                  out_ff <= '{ST_BAD, cmd_ff.index, '0};
                  ov_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
                  state_ff <= S_WALKW;
               end
            end
            S_WALKW: state_ff <= S_WALK;
            S_WALK: begin
               if (rd_ff == MARK_BOUND) begin
                  hi_ff <= last_rd_ff;
                  state_ff <= S_CLR;
               end else if ({{(32-AW){1'b0}}, last_rd_ff} == ENTRIES - 1) begin
                  out_ff <= '{ST_BAD, cmd_ff.index, '0};
                  ov_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
                  state_ff <= S_WALKW;
               end
            end
            S_CLR: begin
               wa_ff <= wa_ff + 1'b1;
               if (wa_ff == hi_ff) begin
                  out_ff <= '{ST_OK, INDEX_W'(lo_ff), INDEX_W'(hi_ff)};
                  ov_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: rtl/two_bit_run_allocator.sv
// two-bit run allocator: a 2-bit mark per entry (free, used, run boundary)
// req channel carries operation, index and count; rsp channel carries
// status, first_index and last_index, one rsp word per req word
// allocate scans from entry 0 for the lowest run of count free entries and
// marks it; probe scans the same way without marking; free clears the run
// starting at index
// the front stage classifies each word (zero count, oversize count, bad
// index, bad operation) and parks it in a two-entry queue; the back stage
// runs the mark memory with a single read and single write port
// the back stage answers trivial errors straight from idle; allocate and
// probe scan the entries in order until the run is found, and allocate then
// writes each entry of the run; free reads the entry at index, walks forward
// to the closing boundary mark, reading and waiting in turn, and then clears
// each entry of the run; the walk and the clear can cross the whole map
// after reset the back stage clears all ENTRIES marks, one per cycle, and
// takes no queued word until that is done; the front still fills its queue
// when rsp stalls the result register holds and the back stage waits
module two_bit_run_allocator #(
   parameter int unsigned ENTRIES = tbra_pkg::ENTRIES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   tbra_req_if.sink   req,
   tbra_rsp_if.source rsp
);
   import tbra_pkg::*;
   logic    q_valid, q_ready;
   cmd_type q_cmd;

   tbra_front #(.ENTRIES(ENTRIES)) u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   tbra_back #(.ENTRIES(ENTRIES)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .rsp(rsp)
   );
endmodule
